@@ hw/rtl/hpdt_pkg.sv @@
// hpdt_pkg: shared types and constants for the hpack dynamic table manager
// request and status codes, queued command word and result word layouts
// no dependencies
package hpdt_pkg;

    localparam int FIELD_W        = 16;
    localparam int REQ_W          = 2;
    localparam int SIZE_W         = 18;   // name + value + overhead, never wider
    localparam int ENTRY_OVERHEAD = 32;
    localparam int STATIC_ENTRIES = 61;
    localparam int SIDX_W         = 6;
    localparam int COUNT_W        = 8;
    localparam int BYTES_W        = 13;
    localparam int IN_DATA_W      = 80;
    localparam int OUT_FIELDS_W   = 54;
    localparam int OUT_DATA_W     = 56;
    localparam int OUT_PAD_W      = OUT_DATA_W - OUT_FIELDS_W;
    localparam int Q_DEPTH        = 2;

    typedef enum logic [REQ_W-1:0] {
        K_INSERT = 2'd0,
        K_LOOKUP = 2'd1,
        K_RESIZE = 2'd2,
        K_NONE   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_OVERSIZE  = 2'd2,
        ST_CLAMPED   = 2'd3
    } t_status;

    // input word, lookup_index in the lowest bits
    typedef struct packed {
        logic [FIELD_W-1:0] new_max_size;
        logic [FIELD_W-1:0] entry_handle;
        logic [FIELD_W-1:0] value_length;
        logic [FIELD_W-1:0] name_length;
        logic [FIELD_W-1:0] lookup_index;
    } t_in_data;

    // decoded request as held in the queue
    typedef struct packed {
        t_kind               kind;
        t_status             status;   // status known at decode time
        logic                hit;      // static table hit
        logic [SIDX_W-1:0]   sidx;
        logic                dyn;      // lookup into the dynamic table
        logic                big;      // entry larger than the storage limit
        logic [FIELD_W-1:0]  arg;      // handle for insert, dynamic position for lookup
        logic [SIZE_W-1:0]   size;     // entry size, or clamped new maximum
    } t_cmd;

    // result word, status in the lowest bits
    typedef struct packed {
        logic [BYTES_W-1:0]  table_bytes;
        logic [COUNT_W-1:0]  entry_count;
        logic [COUNT_W-1:0]  evicted_count;
        logic [FIELD_W-1:0]  found_handle;
        logic [SIDX_W-1:0]   static_index;
        logic                hit_static;
        t_status             status;
    } t_result;

endpackage

@@ hw/rtl/hpdt_front.sv @@
// hpdt_front: accepts request words and classifies them into queue commands
// works out entry size, static/dynamic lookup split and size clamping
// depends on hpdt_pkg
module hpdt_front #(
    parameter int MAX_TABLE_BYTES = 4096
) (
    input  logic                        i_valid,
    input  logic [hpdt_pkg::REQ_W-1:0]  i_req,
    input  hpdt_pkg::t_in_data          i_data,
    output logic                        o_ready,
    output logic                        o_push,
    output hpdt_pkg::t_cmd              o_cmd,
    input  logic                        i_full
);
    import hpdt_pkg::*;

    localparam logic [SIZE_W-1:0] MAX_B = SIZE_W'(MAX_TABLE_BYTES);

    logic [SIZE_W-1:0] ent_bytes;
    logic [SIZE_W-1:0] nmax;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    assign ent_bytes = SIZE_W'(i_data.name_length) + SIZE_W'(i_data.value_length)
                     + SIZE_W'(ENTRY_OVERHEAD);
    assign nmax = SIZE_W'(i_data.new_max_size);

    always_comb begin
        o_cmd        = '0;
        o_cmd.kind   = t_kind'(i_req);
        o_cmd.status = ST_OK;
        case (t_kind'(i_req))
            K_INSERT: begin
                o_cmd.arg  = i_data.entry_handle;
                o_cmd.size = ent_bytes;
                o_cmd.big  = ent_bytes > MAX_B;
            end
            K_LOOKUP: begin
                if (i_data.lookup_index == '0) begin
                    o_cmd.status = ST_BAD_INDEX;
                end else if (i_data.lookup_index <= FIELD_W'(STATIC_ENTRIES)) begin
                    o_cmd.hit  = 1'b1;
                    o_cmd.sidx = i_data.lookup_index[SIDX_W-1:0];
                end else begin
                    // position in the dynamic table, newest is zero
                    o_cmd.dyn = 1'b1;
                    o_cmd.arg = i_data.lookup_index - FIELD_W'(STATIC_ENTRIES + 1);
                end
            end
            K_RESIZE: begin
                if (nmax > MAX_B) begin
                    o_cmd.status = ST_CLAMPED;
                    o_cmd.size   = MAX_B;
                end else begin
                    o_cmd.size = nmax;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

@@ hw/rtl/hpdt_queue.sv @@
// hpdt_queue: short command queue between the decode front and the table back
// register based, first in first out
// depends on hpdt_pkg
module hpdt_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  hpdt_pkg::t_cmd   i_cmd,
    output logic             o_full,
    input  logic             i_pop,
    output hpdt_pkg::t_cmd   o_cmd,
    output logic             o_empty
);
    import hpdt_pkg::*;

    localparam int QAW = $clog2(Q_DEPTH);
    localparam int QCW = $clog2(Q_DEPTH + 1);

    t_cmd           r_slots [Q_DEPTH];
    logic [QAW-1:0] r_wptr, n_wptr;
    logic [QAW-1:0] r_rptr, n_rptr;
    logic [QCW-1:0] r_cnt,  n_cnt;
    logic           do_push, do_pop;

    assign o_full  = r_cnt == QCW'(Q_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_cmd   = r_slots[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wptr = do_push ? r_wptr + 1'b1 : r_wptr;
        n_rptr = do_pop  ? r_rptr + 1'b1 : r_rptr;
        n_cnt  = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wptr] <= i_cmd;
        end
    end

endmodule

@@ hw/rtl/hpdt_back.sv @@
// hpdt_back: carries out queued commands on the dynamic table ring
// owns the handle and size memories, eviction sequencer and result register
// depends on hpdt_pkg
module hpdt_back #(
    parameter int MAX_ENTRIES     = 128,
    parameter int MAX_TABLE_BYTES = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_empty,
    input  hpdt_pkg::t_cmd                      i_cmd,
    output logic                                o_pop,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [hpdt_pkg::OUT_DATA_W-1:0]     o_out_data
);
    import hpdt_pkg::*;

    localparam int AW   = $clog2(MAX_ENTRIES);
    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int SZW  = $clog2(MAX_TABLE_BYTES + 1);
    localparam int CMPW = ((CW > FIELD_W) ? CW : FIELD_W) + 1;
    localparam logic [AW:0]   RING_N = (AW + 1)'(MAX_ENTRIES);
    localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_ENTRIES - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(MAX_ENTRIES);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EVCHK  = 4'b0010,
        S_EVDROP = 4'b0100,
        S_RESP   = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [AW-1:0]      r_newest, n_newest;
    logic [CW-1:0]      r_held, n_held;
    logic [SZW-1:0]     r_used, n_used;
    logic [SZW-1:0]     r_limit, n_limit;
    logic               r_ovalid, n_ovalid;
    t_result            r_odata, n_odata;
    t_cmd               r_cmd, n_cmd;
    t_status            r_status, n_status;
    logic               r_hit, n_hit;
    logic [SIDX_W-1:0]  r_sidx, n_sidx;
    logic               r_dyn, n_dyn;
    logic [CW-1:0]      r_evicted, n_evicted;

    logic [FIELD_W-1:0] r_handles [MAX_ENTRIES];
    logic [SZW-1:0]     r_sizes [MAX_ENTRIES];
    logic [FIELD_W-1:0] r_rd_handle;
    logic [SZW-1:0]     r_rd_size;

    logic               mem_we, handle_re, size_re;
    logic [AW-1:0]      next_slot, raddr_h, raddr_s;
    logic [SZW-1:0]     size_in, size_cur;
    logic [SZW:0]       used_plus;
    logic               need_evict;

    // ring slot of dynamic position pos, newest at position zero
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] newest,
                                              input logic [AW-1:0] pos);
        logic [AW:0] w;
        w = {1'b0, newest} + RING_N - {1'b0, pos};
        if (w >= RING_N) begin
            w = w - RING_N;
        end
        return w[AW-1:0];
    endfunction

    assign next_slot = (r_newest == LAST_SLOT) ? '0 : r_newest + 1'b1;
    assign raddr_h   = slot_of(r_newest, i_cmd.arg[AW-1:0]);
    assign raddr_s   = slot_of(r_newest, AW'(r_held - 1'b1));
    assign size_in   = i_cmd.size[SZW-1:0];
    assign size_cur  = r_cmd.size[SZW-1:0];
    assign used_plus = {1'b0, r_used} + {1'b0, size_cur};

    always_comb begin
        if (r_held == '0) begin
            need_evict = 1'b0;
        end else if (r_cmd.kind == K_INSERT) begin
            need_evict = (used_plus > {1'b0, r_limit}) || (r_held >= FULL_CNT);
        end else begin
            need_evict = r_used > r_limit;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_newest  = r_newest;
        n_held    = r_held;
        n_used    = r_used;
        n_limit   = r_limit;
        n_ovalid  = r_ovalid && !i_out_ready;
        n_odata   = r_odata;
        n_cmd     = r_cmd;
        n_status  = r_status;
        n_hit     = r_hit;
        n_sidx    = r_sidx;
        n_dyn     = r_dyn;
        n_evicted = r_evicted;
        o_pop     = 1'b0;
        mem_we    = 1'b0;
        handle_re = 1'b0;
        size_re   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop     = 1'b1;
                    n_cmd     = i_cmd;
                    n_status  = i_cmd.status;
                    n_hit     = i_cmd.hit;
                    n_sidx    = i_cmd.sidx;
                    n_dyn     = 1'b0;
                    n_evicted = '0;
                    n_state   = S_RESP;
                    case (i_cmd.kind)
                        K_INSERT: begin
                            if (i_cmd.big || size_in > r_limit) begin
                                // entry cannot fit at all: empty the table
                                n_evicted = r_held;
                                n_held    = '0;
                                n_used    = '0;
                                n_status  = ST_OVERSIZE;
                            end else begin
                                n_state = S_EVCHK;
                            end
                        end
                        K_LOOKUP: begin
                            if (i_cmd.dyn) begin
                                if (CMPW'(i_cmd.arg) >= CMPW'(r_held)) begin
                                    n_status = ST_BAD_INDEX;
                                end else begin
                                    n_dyn     = 1'b1;
                                    handle_re = 1'b1;
                                end
                            end
                        end
                        K_RESIZE: begin
                            n_limit = size_in;
                            if (size_in == '0) begin
                                n_evicted = r_held;
                                n_held    = '0;
                                n_used    = '0;
                            end else begin
                                n_state = S_EVCHK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_EVCHK: begin
                if (need_evict) begin
                    size_re = 1'b1;
                    n_state = S_EVDROP;
                end else begin
                    if (r_cmd.kind == K_INSERT) begin
                        mem_we   = 1'b1;
                        n_newest = next_slot;
                        n_held   = r_held + 1'b1;
                        n_used   = used_plus[SZW-1:0];
                    end
                    n_state = S_RESP;
                end
            end
            S_EVDROP: begin
                // drop the oldest entry, size read in the previous cycle
                n_evicted = r_evicted + 1'b1;
                n_held    = r_held - 1'b1;
                if (r_rd_size > r_used || r_held == CW'(1)) begin
                    n_used = '0;
                end else begin
                    n_used = r_used - r_rd_size;
                end
                n_state = S_EVCHK;
            end
            S_RESP: begin
                if (!r_ovalid || i_out_ready) begin
                    n_ovalid              = 1'b1;
                    n_odata.status        = r_status;
                    n_odata.hit_static    = r_hit;
                    n_odata.static_index  = r_sidx;
                    n_odata.found_handle  = r_dyn ? r_rd_handle : '0;
                    n_odata.evicted_count = COUNT_W'(r_evicted);
                    n_odata.entry_count   = COUNT_W'(r_held);
                    n_odata.table_bytes   = BYTES_W'(r_used);
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_newest <= '0;
            r_held   <= '0;
            r_used   <= '0;
            r_limit  <= SZW'(MAX_TABLE_BYTES);
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_newest <= n_newest;
            r_held   <= n_held;
            r_used   <= n_used;
            r_limit  <= n_limit;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_odata   <= n_odata;
        r_cmd     <= n_cmd;
        r_status  <= n_status;
        r_hit     <= n_hit;
        r_sidx    <= n_sidx;
        r_dyn     <= n_dyn;
        r_evicted <= n_evicted;
    end

    // ring memories, one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_handles[next_slot] <= r_cmd.arg;
            r_sizes[next_slot]   <= size_cur;
        end
        if (handle_re) begin
            r_rd_handle <= r_handles[raddr_h];
        end
        if (size_re) begin
            r_rd_size <= r_sizes[raddr_s];
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = {{OUT_PAD_W{1'b0}}, r_odata};

endmodule

@@ hw/rtl/hpack_dynamic_table_manager.sv @@
// hpack_dynamic_table_manager: top level of the hpack dynamic table bookkeeping
// ties the decode front, the command queue and the table back together
// depends on hpdt_pkg, hpdt_front, hpdt_queue, hpdt_back
//
//  channel   dir  data                                          side info
//  s_axis    in   tdata: lookup_index, name_length,             tuser: req_type
//                 value_length, entry_handle, new_max_size
//  m_axis    out  tdata: status, hit_static, static_index,      none
//                 found_handle, evicted_count, entry_count,
//                 table_bytes
//
// a lookup, an oversize insert, an emptying size update or an unused code goes from
// idle straight to the response state in the back end, an insert that fits or another
// size update passes the eviction check first, plus a drop step per entry evicted
// each eviction costs a read of the oldest size from the size memory
// a result is registered through the queue, the back end state and the result register
// synchronous active-low reset empties the table and sets the limit to the maximum
// the queue keeps accepting words until full while a result waits on m_axis_tready
module hpack_dynamic_table_manager #(
    parameter int MAX_ENTRIES     = 128,
    parameter int MAX_TABLE_BYTES = 4096
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // lookup_index, name_length, value_length, entry_handle, new_max_size
    input  logic [hpdt_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // req_type
    input  logic [hpdt_pkg::REQ_W-1:0]           s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // status, hit_static, static_index, found_handle, evicted_count,
    // entry_count, table_bytes, zero pad
    output logic [hpdt_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
    import hpdt_pkg::*;

    // front to queue
    logic push;
    logic q_full;
    t_cmd front_cmd;

    // queue to back
    logic q_empty;
    logic pop;
    t_cmd head_cmd;

    hpdt_front #(
        .MAX_TABLE_BYTES (MAX_TABLE_BYTES)
    ) u_front (
        .i_valid (s_axis_tvalid),
        .i_req   (s_axis_tuser),
        .i_data  (t_in_data'(s_axis_tdata)),
        .o_ready (s_axis_tready),
        .o_push  (push),
        .o_cmd   (front_cmd),
        .i_full  (q_full)
    );

    // two-word queue lets decode run ahead of a long eviction
    hpdt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (q_empty)
    );

    // ring state, memories and result register
    hpdt_back #(
        .MAX_ENTRIES     (MAX_ENTRIES),
        .MAX_TABLE_BYTES (MAX_TABLE_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule

@@ hw/rtl/hpdt_checker.sv @@
// hpdt_checker: port-level assertions for the hpack dynamic table manager
// attached to the top level by the bind statement at the end of this file
// depends on hpdt_pkg
module hpdt_checker #(
    parameter int MAX_ENTRIES     = 128,
    parameter int MAX_TABLE_BYTES = 4096
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [hpdt_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
    import hpdt_pkg::*;

    t_result res;

    assign res = t_result'(m_axis_tdata[OUT_FIELDS_W-1:0]);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // an oversize insert leaves an empty table
    a_oversize_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && res.status == ST_OVERSIZE |->
            res.entry_count == '0 && res.table_bytes == '0 &&
            !res.hit_static && res.found_handle == '0)
        else $error("oversize insert did not empty the table");

    // a static hit carries a static index, no found handle and no evictions
    a_static_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && res.hit_static |->
            res.status == ST_OK && res.static_index != '0 &&
            res.static_index <= SIDX_W'(STATIC_ENTRIES) &&
            res.found_handle == '0 && res.evicted_count == '0)
        else $error("static hit with inconsistent fields");

    // a rejected lookup evicts nothing
    a_bad_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && res.status == ST_BAD_INDEX |->
            res.evicted_count == '0 && !res.hit_static)
        else $error("invalid index result with evictions or hit");

    // occupancy stays within the configured bounds
    a_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (MAX_ENTRIES >= 256 || res.entry_count <= COUNT_W'(MAX_ENTRIES)) &&
            (MAX_TABLE_BYTES >= 8192 || res.table_bytes <= BYTES_W'(MAX_TABLE_BYTES)))
        else $error("table occupancy beyond its bounds");

endmodule

bind hpack_dynamic_table_manager hpdt_checker #(
    .MAX_ENTRIES     (MAX_ENTRIES),
    .MAX_TABLE_BYTES (MAX_TABLE_BYTES)
) u_hpdt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ verif/hpdt_table_checker.sv @@
// hpdt_table_checker: watches both streams of the hpack dynamic table manager,
// keeps its own copy of the table and compares every result word with its own
// depends on hpdt_pkg
module hpdt_table_checker #(
    parameter int RING_DEPTH = 128,
    parameter int BYTE_LIMIT = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    input  logic                            i_s_axis_tready,
    // lookup_index, name_length, value_length, entry_handle, new_max_size
    input  logic [hpdt_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // req_type
    input  logic [hpdt_pkg::REQ_W-1:0]      i_s_axis_tuser,
    input  logic                            i_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // status, hit_static, static_index, found_handle, evicted_count,
    // entry_count, table_bytes, zero pad
    input  logic [hpdt_pkg::OUT_DATA_W-1:0] i_m_axis_tdata,
    output int                              o_fail_count,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import hpdt_pkg::*;

    // shadow of the table: ring of handles and sizes, newest at head_slot
    logic [FIELD_W-1:0] slot_handle [RING_DEPTH];
    int                 slot_bytes  [RING_DEPTH];
    int                 head_slot;
    int                 entries_held;
    int                 bytes_held;
    int                 byte_ceiling;

    t_result            outcome_q [$];
    int                 fails_seen = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic int slot_of(input int pos);
        return (head_slot + RING_DEPTH - pos) % RING_DEPTH;
    endfunction

    function automatic void drop_oldest_entry();
        int s;
        s = slot_of(entries_held - 1);
        if (slot_bytes[s] > bytes_held) begin
            bytes_held = 0;
        end else begin
            bytes_held = bytes_held - slot_bytes[s];
        end
        entries_held = entries_held - 1;
        if (entries_held == 0) begin
            bytes_held = 0;
        end
    endfunction

    // applies one request word to the shadow table, returns the result word it causes
    function automatic t_result table_outcome(input t_kind kind, input t_in_data w);
        t_result r;
        int      ent_bytes;
        int      dyn_pos;
        int      ceiling;
        int      dropped;
        r       = '0;
        dropped = 0;
        case (kind)
            K_INSERT: begin
                ent_bytes = int'(w.name_length) + int'(w.value_length) + ENTRY_OVERHEAD;
                if (ent_bytes > byte_ceiling) begin
                    dropped      = entries_held;
                    entries_held = 0;
                    bytes_held   = 0;
                    r.status     = ST_OVERSIZE;
                end else begin
                    while (entries_held > 0 && (bytes_held + ent_bytes > byte_ceiling
                            || entries_held >= RING_DEPTH)) begin
                        drop_oldest_entry();
                        dropped++;
                    end
                    head_slot              = (head_slot + 1) % RING_DEPTH;
                    slot_handle[head_slot] = w.entry_handle;
                    slot_bytes[head_slot]  = ent_bytes;
                    entries_held           = entries_held + 1;
                    bytes_held             = bytes_held + ent_bytes;
                end
            end
            K_LOOKUP: begin
                if (w.lookup_index == 0) begin
                    r.status = ST_BAD_INDEX;
                end else if (w.lookup_index <= STATIC_ENTRIES) begin
                    r.hit_static   = 1'b1;
                    r.static_index = w.lookup_index[SIDX_W-1:0];
                end else begin
                    dyn_pos = int'(w.lookup_index) - STATIC_ENTRIES - 1;
                    if (dyn_pos >= entries_held) begin
                        r.status = ST_BAD_INDEX;
                    end else begin
                        r.found_handle = slot_handle[slot_of(dyn_pos)];
                    end
                end
            end
            K_RESIZE: begin
                ceiling = int'(w.new_max_size);
                if (ceiling > BYTE_LIMIT) begin
                    ceiling  = BYTE_LIMIT;
                    r.status = ST_CLAMPED;
                end
                byte_ceiling = ceiling;
                if (byte_ceiling == 0) begin
                    dropped      = entries_held;
                    entries_held = 0;
                    bytes_held   = 0;
                end else begin
                    while (entries_held > 0 && bytes_held > byte_ceiling) begin
                        drop_oldest_entry();
                        dropped++;
                    end
                end
            end
            default: begin
                // unused code leaves the table alone
            end
        endcase
        r.evicted_count = dropped[COUNT_W-1:0];
        r.entry_count   = entries_held[COUNT_W-1:0];
        r.table_bytes   = bytes_held[BYTES_W-1:0];
        return r;
    endfunction

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            fails_seen++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            head_slot    = 0;
            entries_held = 0;
            bytes_held   = 0;
            byte_ceiling = BYTE_LIMIT;
            outcome_q.delete();
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                outcome_q.push_back(table_outcome(t_kind'(i_s_axis_tuser),
                                                  t_in_data'(i_s_axis_tdata)));
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got = t_result'(i_m_axis_tdata[OUT_FIELDS_W-1:0]);
                if (outcome_q.size() == 0) begin
                    $display("%0t ns: result word with none expected, expected nothing, got %h",
                             $time, i_m_axis_tdata);
                    fails_seen++;
                end else begin
                    want = outcome_q.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("hit_static", want.hit_static, got.hit_static);
                    check_field("static_index", want.static_index, got.static_index);
                    check_field("found_handle", want.found_handle, got.found_handle);
                    check_field("evicted_count", want.evicted_count, got.evicted_count);
                    check_field("entry_count", want.entry_count, got.entry_count);
                    check_field("table_bytes", want.table_bytes, got.table_bytes);
                end
            end
        end
        o_pending    <= outcome_q.size();
        o_fail_count <= fails_seen;
    end

endmodule

@@ verif/tb_hpack_dynamic_table_manager.sv @@
// tb_hpack_dynamic_table_manager: stimulus and verdict for the hpack dynamic table manager
// directed corner cases, then random request mixes under several idling patterns
// depends on hpdt_pkg, hpack_dynamic_table_manager and hpdt_table_checker
module tb_hpack_dynamic_table_manager;
    timeunit 1ns;
    timeprecision 1ps;

    import hpdt_pkg::*;

    localparam int CLK_PERIOD      = 8;
    localparam int RESET_CYCLES    = 12;
    localparam int RING_DEPTH      = 128;
    localparam int BYTE_LIMIT      = 4096;
    localparam int PHASES          = 4;
    localparam int WORDS_PER_PHASE = 425;
    localparam int HOLD_CYCLES     = 200;   // long receiver hold-off
    localparam int HOLD_WORDS      = 20;    // words offered during the hold-off
    // covers the worst eviction run, every ring entry dropped, with margin
    localparam int TAIL_CYCLES     = 300;
    localparam int TIMEOUT_NS      = 10_000_000;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // lookup_index, name_length, value_length, entry_handle, new_max_size
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    // req_type
    logic [REQ_W-1:0]      s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // status, hit_static, static_index, found_handle, evicted_count,
    // entry_count, table_bytes, zero pad
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    int fail_count;
    int pending_results;

    // idling controls: sender side is local to the stimulus process,
    // receiver side is handed over by nonblocking writes
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    bit rx_hold      = 1'b0;
    int hold_cycles  = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    hpack_dynamic_table_manager #(
        .MAX_ENTRIES     (RING_DEPTH),
        .MAX_TABLE_BYTES (BYTE_LIMIT)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    hpdt_table_checker #(
        .RING_DEPTH (RING_DEPTH),
        .BYTE_LIMIT (BYTE_LIMIT)
    ) table_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending_results)
    );

    // receiver: random stalls, or a counted hold-off while rx_hold is up
    always @(posedge i_clk) begin
        if (rx_hold && hold_cycles < HOLD_CYCLES) begin
            m_axis_tready <= 1'b0;
            hold_cycles++;
        end else begin
            if (!rx_hold) begin
                hold_cycles = 0;
            end
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // safety net against a hung handshake
    initial begin
        #(TIMEOUT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic t_in_data random_word();
        t_in_data w;
        w.lookup_index = 16'($urandom_range(65535));
        w.name_length  = 16'($urandom_range(65535));
        w.value_length = 16'($urandom_range(65535));
        w.entry_handle = 16'($urandom_range(65535));
        w.new_max_size = 16'($urandom_range(65535));
        return w;
    endfunction

    // offers one word after a random idle gap, returns at its acceptance edge
    task automatic send_word(input t_kind kind, input t_in_data w);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        s_axis_tuser  <= kind;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
    endtask

    // fields that the request does not use carry random bits
    task automatic send_insert(input int name_len, input int value_len, input int handle);
        t_in_data w;
        w              = random_word();
        w.name_length  = 16'(name_len);
        w.value_length = 16'(value_len);
        w.entry_handle = 16'(handle);
        send_word(K_INSERT, w);
    endtask

    task automatic send_lookup(input int index);
        t_in_data w;
        w              = random_word();
        w.lookup_index = 16'(index);
        send_word(K_LOOKUP, w);
    endtask

    task automatic send_resize(input int size_cap);
        t_in_data w;
        w              = random_word();
        w.new_max_size = 16'(size_cap);
        send_word(K_RESIZE, w);
    endtask

    // sender pauses until every expected result word has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) begin
            @(posedge i_clk);
        end
    endtask

    // fill the ring with minimum-size entries so the entry limit bites, then probe deep
    task automatic fill_ring(inout int sent);
        int n;
        send_resize(BYTE_LIMIT);
        for (n = 0; n < RING_DEPTH + 2; n++) begin
            send_insert(0, 0, $urandom_range(65535));
        end
        for (n = 0; n < 4; n++) begin
            send_lookup(STATIC_ENTRIES + 1 + $urandom_range(RING_DEPTH - 1));
        end
        send_lookup(STATIC_ENTRIES + RING_DEPTH);
        send_lookup(STATIC_ENTRIES + RING_DEPTH + 1);
        sent += RING_DEPTH + 9;
    endtask

    // one random request, mostly well-formed with sizes that keep the table busy
    task automatic send_random_request(inout int sent);
        int pick;
        int sel;
        pick = $urandom_range(99);
        sel  = $urandom_range(9);
        if (pick < 40) begin
            if (sel == 0) begin
                send_insert($urandom_range(65535), $urandom_range(65535), $urandom_range(65535));
            end else begin
                send_insert($urandom_range(120), $urandom_range(400), $urandom_range(65535));
            end
        end else if (pick < 75) begin
            case (sel)
                0:       send_lookup(0);
                1, 2:    send_lookup($urandom_range(STATIC_ENTRIES, 1));
                8:       send_lookup(STATIC_ENTRIES + 1 + $urandom_range(200));
                9:       send_lookup($urandom_range(65535));
                default: send_lookup(STATIC_ENTRIES + 1 + $urandom_range(24));
            endcase
        end else if (pick < 92) begin
            case (sel)
                0:       send_resize(0);
                1:       send_resize(BYTE_LIMIT);
                2:       send_resize($urandom_range(65535, BYTE_LIMIT + 1));
                6, 7:    send_resize($urandom_range(800, 1));
                8:       send_resize($urandom_range(BYTE_LIMIT, BYTE_LIMIT / 2));
                9:       send_resize($urandom_range(65535));
                default: send_resize($urandom_range(BYTE_LIMIT, 1));
            endcase
        end else if (pick < 95) begin
            send_word(K_NONE, random_word());
        end else begin
            // noise: any code with any payload
            send_word(t_kind'($urandom_range(3)), random_word());
        end
        sent++;
    endtask

    initial begin
        int phase;
        int sent;
        int n;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, static range edges, index zero and far beyond
        send_lookup(0);
        send_lookup(1);
        send_lookup(STATIC_ENTRIES);
        send_lookup(STATIC_ENTRIES + 1);
        send_lookup(65535);
        // smallest entry and extreme handles, then resolve both and one past
        send_insert(0, 0, 16'h0000);
        send_insert(10, 20, 16'hffff);
        send_lookup(STATIC_ENTRIES + 1);
        send_lookup(STATIC_ENTRIES + 2);
        send_lookup(STATIC_ENTRIES + 3);
        // largest lengths: oversize entry empties the table
        send_insert(65535, 65535, 16'h5a5a);
        // entry exactly at the limit, then one that forces its eviction
        send_insert(BYTE_LIMIT - ENTRY_OVERHEAD, 0, 16'h1234);
        send_insert(0, 0, 16'hedcb);
        // one octet over the limit
        send_insert(BYTE_LIMIT - ENTRY_OVERHEAD, 1, 16'h0f0f);
        // clamped size updates
        send_resize(65535);
        send_resize(BYTE_LIMIT + 1);
        // shrink so the oldest goes, then size zero empties
        send_insert(100, 100, 16'ha5a5);
        send_insert(50, 50, 16'h3c3c);
        send_resize(200);
        send_resize(0);
        // any insert is oversize while the limit is zero
        send_insert(0, 0, 16'h7777);
        // unused request code
        send_word(K_NONE, random_word());
        send_resize(BYTE_LIMIT);

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct <= 0;
                end
                1: begin
                    tx_idle_pct  = 71;
                    rx_stall_pct <= 0;
                end
                2: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct <= 71;
                end
                default: begin
                    tx_idle_pct  = 15;
                    rx_stall_pct <= 15;
                end
            endcase
            sent = 0;
            if (phase == 0) begin
                // receiver holds off while the sender keeps offering words
                rx_hold <= 1'b1;
                for (n = 0; n < HOLD_WORDS; n++) begin
                    send_random_request(sent);
                end
                rx_hold <= 1'b0;
                wait_drained();
            end
            if (phase == 1 || phase == 2) begin
                fill_ring(sent);
            end
            while (sent < WORDS_PER_PHASE) begin
                send_random_request(sent);
            end
            wait_drained();
        end

        // end of run: free receiver, let the last results and any stragglers show
        rx_stall_pct <= 0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
